// ===== design/band_energy_onset_detector_unit_defines.svh =====
// Assertion macros for the band energy onset detector.
// Used by band_energy_onset_detector_unit; expects i_clk and i_rst_n in scope.
`ifndef BAND_ENERGY_ONSET_DETECTOR_UNIT_DEFINES_SVH
`define BAND_ENERGY_ONSET_DETECTOR_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define BONSD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bonsd assertion failed");
// next-cycle implication
`define BONSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bonsd assertion failed");
`else
`define BONSD_ASSERT_IMPL(label, ante, cons)
`define BONSD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/bonsd_pkg.sv =====
// Shared types and constants for the band energy onset detector.
// No dependencies; imported by band_energy_onset_detector_unit and the testbench.
`timescale 1ns / 1ps

package bonsd_pkg;

    // parameter defaults
    localparam int MAX_BINS_DEF  = 1024;
    localparam int MAG_WIDTH_DEF = 16;

    // fixed field widths
    localparam int MAG_W      = 16;
    localparam int STAMP_W    = 32;
    localparam int ENERGY_W   = 16;
    localparam int LEVEL_W    = 24;    // Q16.8
    localparam int RATIO_W    = 8;     // Q4.4
    localparam int WARM_W     = 8;
    localparam int FIRST_W    = 10;
    localparam int END_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int LVL_SUM_W  = LEVEL_W + 3;  // 4*level + energy<<8
    localparam int PROD_W     = LEVEL_W + RATIO_W;
    localparam int LVL_SHIFT  = 8;
    localparam int CMP_SHIFT  = 12;

    // register reset values
    localparam logic [FIRST_W-1:0] BAND_FIRST_RST = 10'd46;
    localparam logic [END_W-1:0]   BAND_END_RST   = 11'd69;
    localparam logic [RATIO_W-1:0] RATIO_RST      = 8'd96;   // 6.0
    localparam logic [WARM_W-1:0]  WARM_RST       = 8'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP     = 2'd3;

    // 0.8 / 0.2 average: (4*old + new) / 5
    localparam logic [2:0] LEVEL_DIVISOR = 3'd5;

    // divide by five as a reciprocal multiply: ceil(2^29 / 5), exact for sums below 2^27
    localparam int                   LVL_PROD_W      = 2 * LVL_SUM_W;
    localparam int                   LVL_RECIP_SHIFT = 29;
    localparam logic [LVL_SUM_W-1:0] LVL_RECIP       = 27'd107374183;

    localparam logic [WARM_W-1:0] ACC_MAX = 8'hFF;

    typedef enum logic [2:0] {
        S_ACC,    // taking bins
        S_SETUP,  // window closed, size the band
        S_EDIV,   // energy = sum / band bins
        S_EVAL,   // peak, click test, level fold
        S_LDIV,   // level average, reciprocal multiply
        S_FIN     // hand result to output register
    } t_state;

endpackage

// ===== design/bonsd_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters; instantiated by the top level.
`timescale 1ns / 1ps

module bonsd_div #(
    parameter int DIVIDEND_W = 27,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_count;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;
    logic               ge;

    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_count == CNT_W'(1));
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_count <= r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
            r_rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/band_energy_onset_detector_unit.sv =====
// Band energy onset detector: top level with bin accumulator and sequencer.
// Depends on bonsd_pkg, bonsd_div and band_energy_onset_detector_unit_defines.svh.
//
//  channel   | direction | handshake                          | payload
//  ----------+-----------+------------------------------------+------------------------------
//  s_axis    | in        | i_s_axis_tvalid / o_s_axis_tready  | tdata, tlast = last bin
//  m_axis    | out       | o_m_axis_tvalid / i_m_axis_tready  | tdata, tuser = click flags
//  cfg       | in        | i_cfg_valid / o_cfg_ready          | i_cfg_index, i_cfg_data
//
// A bin that does not close a window does not stall the input. After a closing bin the
// input is held off through set-up, the energy division on the bit-serial divider,
// evaluate and hand-off. A level fold adds a state (divide by five as a reciprocal
// multiply); an empty band skips the divider.
// Reset is synchronous, active low; no clearing pass.
// A result waits in the output register while the next window's bins stream in;
// a further window end holds in the hand-off state until that register frees.
`timescale 1ns / 1ps
`include "band_energy_onset_detector_unit_defines.svh"

module band_energy_onset_detector_unit #(
    parameter int MAX_BINS  = bonsd_pkg::MAX_BINS_DEF,
    parameter int MAG_WIDTH = bonsd_pkg::MAG_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // bin stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [47:0]                         i_s_axis_tdata,  // magnitude[15:0], window_stamp[47:16]
    input  logic                                i_s_axis_tlast,  // last_bin
    // window results
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [63:0]                         o_m_axis_tdata,  // window_energy[15:0], click_stamp[47:16],
                                                                 // peak[63:48]
    output logic [2:0]                          o_m_axis_tuser,  // click[0], first_click[1], click_seen[2]
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bonsd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bonsd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import bonsd_pkg::*;

    // effective magnitude bits and derived widths
    localparam int MW    = (MAG_WIDTH < MAG_W) ? MAG_WIDTH : MAG_W;
    localparam int SUM_W = MW + $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int CMP_W = (CNT_W > END_W) ? CNT_W : END_W;
    localparam int DIV_W = (SUM_W > LVL_SUM_W) ? SUM_W : LVL_SUM_W;
    localparam int DV_W  = CMP_W;

    // configuration
    logic [FIRST_W-1:0] r_band_first;
    logic [END_W-1:0]   r_band_end;
    logic [RATIO_W-1:0] r_ratio;
    logic [WARM_W-1:0]  r_warm;

    // sequencer and detector state
    t_state              r_state,     n_state;
    logic [CNT_W-1:0]    r_cnt,       n_cnt;
    logic [SUM_W-1:0]    r_sum,       n_sum;
    logic [STAMP_W-1:0]  r_stamp,     n_stamp;
    logic [ENERGY_W-1:0] r_energy,    n_energy;
    logic [LEVEL_W-1:0]  r_level,     n_level;
    logic [WARM_W-1:0]   r_acc,       n_acc;
    logic [ENERGY_W-1:0] r_peak,      n_peak;
    logic                r_flag,      n_flag;
    logic [STAMP_W-1:0]  r_det_stamp, n_det_stamp;
    logic                r_click,     n_click;
    logic                r_first,     n_first;

    // output register
    logic                r_out_valid,  n_out_valid;
    logic [ENERGY_W-1:0] r_out_energy, n_out_energy;
    logic                r_out_click,  n_out_click;
    logic                r_out_first,  n_out_first;
    logic [STAMP_W-1:0]  r_out_stamp,  n_out_stamp;
    logic                r_out_seen,   n_out_seen;
    logic [ENERGY_W-1:0] r_out_peak,   n_out_peak;

    // divider hookup
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_quotient;
    logic [DV_W-1:0]  div_divisor;
    logic             div_done;

    // datapath terms
    logic                  in_xfer;
    logic                  out_xfer;
    logic [MW-1:0]         mag;
    logic [CMP_W-1:0]      idx;
    logic [CMP_W-1:0]      first_x;
    logic [CMP_W-1:0]      end_x;
    logic [CMP_W-1:0]      n_bins;
    logic [CMP_W-1:0]      band_span;
    logic                  cnt_sat;
    logic                  in_band;
    logic [ENERGY_W-1:0]   energy_sat;
    logic [PROD_W-1:0]     cmp_lhs;
    logic [PROD_W-1:0]     cmp_rhs;
    logic                  click_hit;
    logic [LVL_SUM_W-1:0]  lvl_sum;
    logic [LVL_PROD_W-1:0] lvl_prod;
    logic [WARM_W-1:0]     acc_inc;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_ACC);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer        = r_out_valid && i_m_axis_tready;

    assign mag     = i_s_axis_tdata[MW-1:0];
    assign idx     = CMP_W'(r_cnt);
    assign first_x = CMP_W'(r_band_first);
    assign end_x   = CMP_W'(r_band_end);
    assign cnt_sat = (r_cnt == CNT_W'(MAX_BINS));
    assign in_band = !cnt_sat && (idx >= first_x) && (idx < end_x);

    // band clipped to the bins received
    assign n_bins    = (idx < end_x) ? idx : end_x;
    assign band_span = n_bins - first_x;

    assign energy_sat = (|div_quotient[DIV_W-1:ENERGY_W]) ? {ENERGY_W{1'b1}}
                                                          : div_quotient[ENERGY_W-1:0];

    // energy << 12 against level * ratio, both exact
    assign cmp_lhs   = PROD_W'({r_energy, {CMP_SHIFT{1'b0}}});
    assign cmp_rhs   = PROD_W'(r_level) * PROD_W'(r_ratio);
    assign click_hit = (r_acc >= r_warm) && (cmp_lhs > cmp_rhs);

    assign lvl_sum = LVL_SUM_W'({r_level, 2'b00}) + LVL_SUM_W'({r_energy, {LVL_SHIFT{1'b0}}});
    // floor(lvl_sum / 5)
    assign lvl_prod = LVL_PROD_W'(lvl_sum) * LVL_PROD_W'(LVL_RECIP);
    assign acc_inc  = (r_acc == ACC_MAX) ? r_acc : r_acc + WARM_W'(1);

    bonsd_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_first <= BAND_FIRST_RST;
            r_band_end   <= BAND_END_RST;
            r_ratio      <= RATIO_RST;
            r_warm       <= WARM_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BAND_FIRST: r_band_first <= i_cfg_data[FIRST_W-1:0];
                CFG_BAND_END:   r_band_end   <= i_cfg_data[END_W-1:0];
                CFG_RATIO:      r_ratio      <= i_cfg_data[RATIO_W-1:0];
                CFG_WARMUP:     r_warm       <= i_cfg_data[WARM_W-1:0];
            endcase
        end
    end

    // sequencer: next state and datapath
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_sum        = r_sum;
        n_stamp      = r_stamp;
        n_energy     = r_energy;
        n_level      = r_level;
        n_acc        = r_acc;
        n_peak       = r_peak;
        n_flag       = r_flag;
        n_det_stamp  = r_det_stamp;
        n_click      = r_click;
        n_first      = r_first;
        n_out_valid  = out_xfer ? 1'b0 : r_out_valid;
        n_out_energy = r_out_energy;
        n_out_click  = r_out_click;
        n_out_first  = r_out_first;
        n_out_stamp  = r_out_stamp;
        n_out_seen   = r_out_seen;
        n_out_peak   = r_out_peak;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        unique case (r_state)
            S_ACC: begin
                if (in_xfer) begin
                    if (in_band) begin
                        n_sum = r_sum + SUM_W'(mag);
                    end
                    if (!cnt_sat) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    if (i_s_axis_tlast) begin
                        n_stamp = i_s_axis_tdata[47:16];
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                if (n_bins > first_x) begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(r_sum);
                    div_divisor  = DV_W'(band_span);
                    n_state      = S_EDIV;
                end else begin
                    // empty band
                    n_energy = '0;
                    n_state  = S_EVAL;
                end
            end
            S_EDIV: begin
                if (div_done) begin
                    n_energy = energy_sat;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_energy > r_peak) begin
                    n_peak = r_energy;
                end
                n_click = click_hit;
                n_first = 1'b0;
                if (!click_hit) begin
                    if (r_acc == '0) begin
                        n_level = {r_energy, {LVL_SHIFT{1'b0}}};
                        n_acc   = acc_inc;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_LDIV;
                    end
                end else begin
                    if (!r_flag) begin
                        n_flag      = 1'b1;
                        n_det_stamp = r_stamp;
                        n_first     = 1'b1;
                    end
                    n_state = S_FIN;
                end
            end
            S_LDIV: begin
                n_level = lvl_prod[LVL_RECIP_SHIFT +: LEVEL_W];
                n_acc   = acc_inc;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_energy = r_energy;
                    n_out_click  = r_click;
                    n_out_first  = r_first;
                    n_out_stamp  = r_det_stamp;
                    n_out_seen   = r_flag;
                    n_out_peak   = r_peak;
                    n_cnt        = '0;
                    n_sum        = '0;
                    n_state      = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    // control and detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_level     <= '0;
            r_acc       <= '0;
            r_peak      <= '0;
            r_flag      <= 1'b0;
            r_det_stamp <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_level     <= n_level;
            r_acc       <= n_acc;
            r_peak      <= n_peak;
            r_flag      <= n_flag;
            r_det_stamp <= n_det_stamp;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_stamp      <= n_stamp;
        r_energy     <= n_energy;
        r_click      <= n_click;
        r_first      <= n_first;
        r_out_energy <= n_out_energy;
        r_out_click  <= n_out_click;
        r_out_first  <= n_out_first;
        r_out_stamp  <= n_out_stamp;
        r_out_seen   <= n_out_seen;
        r_out_peak   <= n_out_peak;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_peak, r_out_stamp, r_out_energy};
    assign o_m_axis_tuser  = {r_out_seen, r_out_first, r_out_click};

    // a closing bin stops intake while the window is evaluated
    `BONSD_ASSERT_NEXT(a_last_bin_stalls, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, !o_s_axis_tready)
    // a first click is a click and is latched
    `BONSD_ASSERT_IMPL(a_first_is_seen, o_m_axis_tvalid && o_m_axis_tuser[1], o_m_axis_tuser[0] && o_m_axis_tuser[2])
    // peak covers the window it reports with
    `BONSD_ASSERT_IMPL(a_peak_covers, o_m_axis_tvalid, o_m_axis_tdata[63:48] >= o_m_axis_tdata[15:0])

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for band_energy_onset_detector_unit: streams spectrum bins,
// predicts each window result in a scoreboard class and checks it field by field.
// Depends on bonsd_pkg and the design sources only.
`timescale 1ns / 1ps

module testbench;
    import bonsd_pkg::*;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the detector state and registers. Every
    // accepted bin is folded in; a closing bin queues the window result.
    // ------------------------------------------------------------------
    class onset_scoreboard;
        typedef struct {
            logic [ENERGY_W-1:0] energy;
            logic                click;
            logic                first;
            logic [STAMP_W-1:0]  stamp;
            logic                seen;
            logic [ENERGY_W-1:0] peak;
        } t_window_result;

        logic [FIRST_W-1:0]  band_first;
        logic [END_W-1:0]    band_end;
        logic [RATIO_W-1:0]  ratio;
        logic [WARM_W-1:0]   warmup;

        logic [END_W-1:0]    bin_count;
        logic [25:0]         band_sum;
        logic [LEVEL_W-1:0]  level;
        logic [WARM_W-1:0]   quiet_windows;
        logic [ENERGY_W-1:0] peak;
        logic                seen;
        logic [STAMP_W-1:0]  latched_stamp;

        t_window_result      pending_windows[$];
        int                  mismatches;

        function new();
            band_first    = BAND_FIRST_RST;
            band_end      = BAND_END_RST;
            ratio         = RATIO_RST;
            warmup        = WARM_RST;
            bin_count     = '0;
            band_sum      = '0;
            level         = '0;
            quiet_windows = '0;
            peak          = '0;
            seen          = 1'b0;
            latched_stamp = '0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_BAND_FIRST: band_first = val[FIRST_W-1:0];
                CFG_BAND_END:   band_end   = val[END_W-1:0];
                CFG_RATIO:      ratio      = val[RATIO_W-1:0];
                CFG_WARMUP:     warmup     = val[WARM_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_windows.size();
        endfunction

        function void note_bin(logic [MAG_W-1:0] mag, logic [STAMP_W-1:0] stamp, logic last);
            longint unsigned quot;
            longint unsigned lhs;
            longint unsigned rhs;
            longint unsigned lvl;
            int unsigned     n;
            t_window_result  r;
            if (bin_count < MAX_BINS_DEF && bin_count >= band_first && bin_count < band_end)
                band_sum = band_sum + 26'(mag);
            if (bin_count < MAX_BINS_DEF)
                bin_count++;
            if (!last)
                return;

            // band clipped to the bins actually received
            n = (bin_count < band_end) ? 32'(bin_count) : 32'(band_end);
            r.energy = '0;
            if (n > band_first) begin
                quot = 64'(band_sum) / 64'(n - band_first);
                r.energy = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
            end
            if (r.energy > peak)
                peak = r.energy;

            lhs = 64'(r.energy) << CMP_SHIFT;
            rhs = 64'(level) * 64'(ratio);
            r.click = (quiet_windows >= warmup) && (lhs > rhs);
            r.first = 1'b0;

            if (!r.click) begin
                lvl = 64'(r.energy) << LVL_SHIFT;
                if (quiet_windows != 0)
                    lvl = (4 * 64'(level) + lvl) / 64'(LEVEL_DIVISOR);
                level = lvl[LEVEL_W-1:0];
                if (quiet_windows != ACC_MAX)
                    quiet_windows++;
            end else if (!seen) begin
                seen          = 1'b1;
                latched_stamp = stamp;
                r.first       = 1'b1;
            end

            bin_count = '0;
            band_sum  = '0;
            r.stamp   = latched_stamp;
            r.seen    = seen;
            r.peak    = peak;
            pending_windows.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %s: got %0h want %0h", name, got, want);
            end
        endfunction

        function void check_window(logic [63:0] tdata, logic [2:0] tuser);
            t_window_result want;
            if (pending_windows.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected window result: tdata %0h tuser %0h", tdata, tuser);
                return;
            end
            want = pending_windows.pop_front();
            compare_field("window_energy", 32'(tdata[15:0]),  32'(want.energy));
            compare_field("click_stamp",   tdata[47:16],      want.stamp);
            compare_field("peak",          32'(tdata[63:48]), 32'(want.peak));
            compare_field("click",         32'(tuser[0]),     32'(want.click));
            compare_field("first_click",   32'(tuser[1]),     32'(want.first));
            compare_field("click_seen",    32'(tuser[2]),     32'(want.seen));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [47:0]           i_s_axis_tdata  = '0;   // magnitude[15:0], window_stamp[47:16]
    logic                  i_s_axis_tlast  = 1'b0; // last_bin
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [63:0]           o_m_axis_tdata;         // window_energy, click_stamp, peak
    logic [2:0]            o_m_axis_tuser;         // click, first_click, click_seen
    logic                  o_cfg_ready;

    onset_scoreboard sb = new();

    // idle percentages, switched as the random part goes on
    int unsigned tx_idle_pct = 30;
    int unsigned rx_idle_pct = 53;
    int unsigned rand_bins   = 0;
    // one-shot request for a long output stall
    logic        stall_req   = 1'b0;

    band_energy_onset_detector_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // hard stop in case the DUT hangs
    initial begin : watchdog
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random backpressure, plus one long counted hold so the
    // output register and the hand-off state both fill and stall input
    // ------------------------------------------------------------------
    initial begin : result_ready_gen
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                hold_left = 400;
                stall_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // result monitor: outputs sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_window(o_m_axis_tdata, o_m_axis_tuser);
    end

    // ------------------------------------------------------------------
    // Drivers: inputs change at the falling edge
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_band(logic [FIRST_W-1:0] first_bin, logic [END_W-1:0] end_bin,
                            logic [RATIO_W-1:0] ratio_q44, logic [WARM_W-1:0] warm);
        write_reg(CFG_BAND_FIRST, CFG_DATA_W'(first_bin));
        write_reg(CFG_BAND_END,   CFG_DATA_W'(end_bin));
        write_reg(CFG_RATIO,      CFG_DATA_W'(ratio_q44));
        write_reg(CFG_WARMUP,     CFG_DATA_W'(warm));
    endtask

    // one bin transfer; the idle mode follows the random bin count
    task automatic send_bin(logic [MAG_W-1:0] mag, logic [STAMP_W-1:0] stamp, logic last);
        if (rand_bins < 300) begin
            tx_idle_pct = 30;
            rx_idle_pct = 53;
        end else if (rand_bins < 600) begin
            tx_idle_pct = 53;
            rx_idle_pct = 30;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {stamp, mag};
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_bin(mag, stamp, last);
    endtask

    // one spectrum window: mostly quiet bins, loud windows make onsets,
    // with stray full-range bins and stamps that change mid-window as noise
    task automatic send_window(int len, logic loud);
        logic [STAMP_W-1:0] stamp;
        logic [MAG_W-1:0]   mag;
        stamp = $urandom();
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0)
                stamp = $urandom();
            if ($urandom_range(0, 9) == 0)
                mag = MAG_W'($urandom());
            else if (loud)
                mag = MAG_W'($urandom_range(16'h4000, 16'hFFFF));
            else
                mag = MAG_W'($urandom_range(0, 16'h01FF));
            send_bin(mag, stamp, i == len - 1);
            rand_bins++;
        end
    endtask

    // sender pauses until every window result has come, then lets the
    // divider finish before any register write
    task automatic settle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int quota;
        int min_len;
        int max_len;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: tiny band so short windows reach it, warm-up of zero
        set_band(10'd1, 11'd3, 8'd16, 8'd0);
        // band clipped to received bins; first window clicks on level zero
        send_bin(16'h0000, 32'hFFFF_FFFF, 1'b0);
        send_bin(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        // single bin: empty band, energy 0 folded as non-click
        send_bin(16'hFFFF, 32'h0000_0000, 1'b1);
        // full-scale band, later click keeps the latched stamp
        send_bin(16'h1234, 32'h0000_0001, 1'b0);
        send_bin(16'hFFFF, 32'h0000_0001, 1'b0);
        send_bin(16'hFFFF, 32'h0000_0001, 1'b0);
        send_bin(16'h0001, 32'h0000_0001, 1'b1);
        send_bin(16'h0000, 32'h8000_0000, 1'b0);
        send_bin(16'h0000, 32'h8000_0000, 1'b1);
        settle();
        // warm-up holds clicks back, then quiet level is compared
        set_band(10'd0, 11'd2, 8'd16, 8'd3);
        send_bin(16'h0100, 32'h5555_5555, 1'b1);
        send_bin(16'h0100, 32'hAAAA_AAAA, 1'b1);
        send_bin(16'h0100, 32'h0F0F_0F0F, 1'b0);
        send_bin(16'h0100, 32'h0F0F_0F0F, 1'b1);
        send_bin(16'h8000, 32'hF0F0_F0F0, 1'b0);
        send_bin(16'h8000, 32'hF0F0_F0F0, 1'b1);
        settle();

        // random phases, each with its own register setting
        for (int p = 0; p < 8; p++) begin
            min_len = 1;
            max_len = 20;
            case (p)
                0: begin
                    // reset values again: wide windows reach the default band
                    set_band(BAND_FIRST_RST, BAND_END_RST, RATIO_RST, WARM_RST);
                    min_len = 40;
                    max_len = 80;
                end
                1: set_band(10'd0, 11'd1024, 8'd255, 8'd255);
                2: begin
                    // empty band throughout
                    set_band(10'd0, 11'd0, 8'd0, 8'd0);
                    max_len = 12;
                end
                3: begin
                    set_band(10'd0, 11'd8, 8'd0, 8'd2);
                    max_len = 16;
                end
                default: set_band(FIRST_W'($urandom_range(0, 5)), END_W'($urandom_range(0, 16)),
                                  RATIO_W'($urandom_range(0, 255)), WARM_W'($urandom_range(0, 6)));
            endcase
            // long output stall while bins keep coming
            if (p == 3)
                stall_req = 1'b1;
            quota = rand_bins + 100;
            while (rand_bins < quota)
                send_window($urandom_range(min_len, max_len), $urandom_range(0, 7) == 0);
            settle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/bonsd_pkg.sv
design/bonsd_div.sv
design/band_energy_onset_detector_unit.sv
tb/testbench.sv
